/* hw/rtl/rfhwm_pkg.sv */
// ----------------------------------------------------------------------------
// rfhwm_pkg
// Types and constants for the ring FIFO with high-water mark.
// ----------------------------------------------------------------------------
package rfhwm_pkg;

  localparam int DEPTH     = 16;
  localparam int ITEM_BITS = 32;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_POP   = 2'd1,
    FUNC_PEEK  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SEND
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

/* hw/rtl/rfhwm_in_if.sv */
// ----------------------------------------------------------------------------
// rfhwm_in_if
// Operation channel: one word carries an operation code and a data item.
// ----------------------------------------------------------------------------
interface rfhwm_in_if;
  import rfhwm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [ITEM_BITS-1:0] data_in;

  modport source (output valid, output func, output data_in, input ready);
  modport sink   (input valid, input func, input data_in, output ready);

endinterface

/* hw/rtl/rfhwm_out_if.sv */
// ----------------------------------------------------------------------------
// rfhwm_out_if
// Result channel: data read, status, fill level and high-water mark.
// ----------------------------------------------------------------------------
interface rfhwm_out_if;
  import rfhwm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [ITEM_BITS-1:0] data_out;
  logic [STAT_W-1:0]    status;
  logic [CNT_W-1:0]     fill_level;
  logic [CNT_W-1:0]     high_water;

  modport source (output valid, output data_out, output status, output fill_level,
                  output high_water, input ready);
  modport sink   (input valid, input data_out, input status, input fill_level,
                  input high_water, output ready);

endinterface

/* hw/rtl/rfhwm_ctrl.sv */
// ----------------------------------------------------------------------------
// rfhwm_ctrl
// Sequencer: accept a word, execute it, hand the result to the output register.
// ----------------------------------------------------------------------------
module rfhwm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  rfhwm_pkg::dp_status_t dp_st,
  output logic                  in_ready,
  output rfhwm_pkg::cmd_t       cmd
);
  import rfhwm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_SEND;
      end
      S_SEND: begin
        if (dp_st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_SEND: begin
        cmd.load_out = dp_st.out_free;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/rfhwm_dp.sv */
// ----------------------------------------------------------------------------
// rfhwm_dp
// Datapath: ring store, pointers, fill and peak counters, output register.
// ----------------------------------------------------------------------------
module rfhwm_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rfhwm_pkg::cmd_t                 cmd,
  output rfhwm_pkg::dp_status_t           dp_st,
  input  logic [rfhwm_pkg::FUNC_W-1:0]    in_func,
  input  logic [rfhwm_pkg::ITEM_BITS-1:0] in_data,
  input  logic                            cfg_we,
  input  logic [rfhwm_pkg::CNT_W-1:0]     cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [rfhwm_pkg::ITEM_BITS-1:0] out_data,
  output logic [rfhwm_pkg::STAT_W-1:0]    out_status,
  output logic [rfhwm_pkg::CNT_W-1:0]     out_fill,
  output logic [rfhwm_pkg::CNT_W-1:0]     out_hw
);
  import rfhwm_pkg::*;

  logic [ITEM_BITS-1:0] mem [DEPTH];

  logic [FUNC_W-1:0]    func_r;
  logic [ITEM_BITS-1:0] din_r;
  logic [CNT_W-1:0]     depth_r;
  logic [PTR_W-1:0]     wp_r, wp_nxt;
  logic [PTR_W-1:0]     rp_r, rp_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     hw_r, hw_nxt;
  logic [ITEM_BITS-1:0] rd_data_r;
  logic                 hit_r, hit_nxt;
  logic [STAT_W-1:0]    stat_r, stat_nxt;

  logic                 out_valid_r;
  logic [ITEM_BITS-1:0] out_data_r;
  logic [STAT_W-1:0]    out_status_r;
  logic [CNT_W-1:0]     out_fill_r;
  logic [CNT_W-1:0]     out_hw_r;

  logic [CNT_W-1:0]     eff_depth;
  logic                 full, empty, do_write;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] pos,
                                               input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] nx;
    nx = CNT_W'(pos) + CNT_W'(1);
    if (nx >= lim) return '0;
    return nx[PTR_W-1:0];
  endfunction

  // depth 0 acts as 1, anything above DEPTH acts as DEPTH
  always_comb begin
    eff_depth = depth_r;
    if (depth_r == '0) eff_depth = CNT_W'(1);
    else if (depth_r > CNT_W'(DEPTH)) eff_depth = CNT_W'(DEPTH);
  end

  assign full  = (cnt_r >= eff_depth);
  assign empty = (cnt_r == '0);

  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    cnt_nxt  = cnt_r;
    hw_nxt   = hw_r;
    hit_nxt  = 1'b0;
    stat_nxt = STAT_OK;
    do_write = 1'b0;
    case (func_r)
      FUNC_PUSH: begin
        if (full) begin
          stat_nxt = STAT_FULL;
        end else begin
          do_write = 1'b1;
          wp_nxt   = advance(wp_r, eff_depth);
          cnt_nxt  = cnt_r + CNT_W'(1);
          if (cnt_nxt > hw_r) hw_nxt = cnt_nxt;
        end
      end
      FUNC_POP, FUNC_PEEK: begin
        if (empty) begin
          stat_nxt = STAT_EMPTY;
        end else begin
          hit_nxt = 1'b1;
          if (func_r == FUNC_POP) begin
            rp_nxt  = advance(rp_r, eff_depth);
            cnt_nxt = cnt_r - CNT_W'(1);
          end
        end
      end
      default: begin
        wp_nxt  = '0;
        rp_nxt  = '0;
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_func;
      din_r  <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_write) mem[wp_r] <= din_r;
    if (cmd.exec) rd_data_r <= mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      hit_r  <= hit_nxt;
      stat_r <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= CNT_W'(DEPTH);
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
      hw_r    <= '0;
    end else if (cfg_we) begin
      depth_r <= cfg_data;
      wp_r    <= '0;
      rp_r    <= '0;
      cnt_r   <= '0;
    end else if (cmd.exec) begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
      hw_r  <= hw_nxt;
    end
  end

  // output register
  assign dp_st.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r   <= hit_r ? rd_data_r : '0;
      out_status_r <= stat_r;
      out_fill_r   <= cnt_r;
      out_hw_r     <= hw_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_status = out_status_r;
  assign out_fill   = out_fill_r;
  assign out_hw     = out_hw_r;

endmodule

/* hw/rtl/ring_fifo_with_high_water_mark.sv */
// ----------------------------------------------------------------------------
// ring_fifo_with_high_water_mark
// Circular FIFO with configurable depth in use and a high-water mark.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  in_ch   | in  | func, data_in (push / pop / peek / clear)
//  out_ch  | out | data_out, status, fill_level, high_water
//  cfg_*   | in  | depth_in_use write (cfg_we, cfg_data)
//
//  Each word passes three steps: accept, execute (store access), load output.
//  The store's registered read port sets the execute step.
//  A new word is accepted while a result waits in the output register.
//  Reset: synchronous, active low; empties the FIFO, depth 16, mark 0.
//  A depth write empties the FIFO and keeps the high-water mark.
// ----------------------------------------------------------------------------
module ring_fifo_with_high_water_mark (
  input  logic                        clk,
  input  logic                        rst_n,
  rfhwm_in_if.sink                    in_ch,
  rfhwm_out_if.source                 out_ch,
  input  logic                        cfg_we,
  input  logic [rfhwm_pkg::CNT_W-1:0] cfg_data
);
  import rfhwm_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_st;

  rfhwm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .dp_st    (dp_st),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  rfhwm_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .dp_st      (dp_st),
    .in_func    (in_ch.func),
    .in_data    (in_ch.data_in),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_data   (out_ch.data_out),
    .out_status (out_ch.status),
    .out_fill   (out_ch.fill_level),
    .out_hw     (out_ch.high_water)
  );

endmodule
